/* design/sgvs_pkg.sv */
// Shared types, widths and codes for the star glyph vertex shader.
`default_nettype none

package sgvs_pkg;

    localparam int IDX_W      = 10;
    localparam int BASE_W     = 16;
    localparam int ENTRY_W    = 3 * BASE_W;
    localparam int POS_W      = 24;
    localparam int RAD_W      = 16;
    localparam int ERR_W      = 16;
    localparam int ANISO_W    = 16;
    localparam int SCALE_W    = 16;
    localparam int THR_W      = 15;
    localparam int GAIN_W     = 32;
    localparam int PROD_W     = 48;
    localparam int REM_W      = 23;
    localparam int DIV_W      = 22;
    localparam int Q_W        = 8;
    localparam int CH_W       = 8;
    localparam int DIV_STEPS  = 8;
    localparam int S_DATA_W   = 184;
    localparam int M_DATA_W   = 96;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_GEN   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE        = 2'd0,
        CFG_ERR_THRESH   = 2'd1,
        CFG_ANISO_THRESH = 2'd2
    } cfg_index_t;

    localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd1300;
    localparam logic [THR_W-1:0]   ERR_THRESH_RST = 15'd30;
    localparam logic [ANISO_W-1:0] ANISO_RST      = 16'd0;

    localparam logic [CH_W-1:0]  CH_FULL = 8'hFF;
    localparam logic [POS_W-1:0] POS_MAX = 24'h7F_FFFF;
    localparam logic [POS_W-1:0] POS_MIN = 24'h80_0000;

    // Round-to-nearest bias for dropping 22 fraction bits.
    localparam logic [PROD_W:0] ROUND_BIAS = 49'd2097152;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } div_state_t;

    typedef struct packed {
        logic                    in_range;
        logic                    vis;
        logic                    err_pos;
        logic                    last;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [GAIN_W-1:0]       gain;
        logic [THR_W-1:0]        mag;
        logic [THR_W-1:0]        thr;
    } st1_t;

    typedef struct packed {
        logic                     vis;
        logic                     err_pos;
        logic                     last;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [PROD_W-1:0] prod_x;
        logic signed [PROD_W-1:0] prod_y;
        logic signed [PROD_W-1:0] prod_z;
        logic [REM_W-1:0]         num;
        logic [THR_W-1:0]         thr;
    } st2_t;

    typedef struct packed {
        logic             vis;
        logic             err_pos;
        logic             last;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [DIV_W-1:0] div;
        div_state_t       ds;
    } dv_t;

endpackage

`default_nettype wire

/* design/sgvs_table_ram.sv */
// Base vertex table: one write port, one registered read port.
`default_nettype none

module sgvs_table_ram
    import sgvs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [ENTRY_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [AW-1:0]      raddr,
    output logic      [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data while the consuming stage is stalled.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/sgvs_div_step.sv */
// One restoring division step: yields one quotient bit, MSB first.
`default_nettype none

module sgvs_div_step
    import sgvs_pkg::*;
(
    input  wire div_state_t       cur,
    input  wire logic [DIV_W-1:0] divisor,
    output div_state_t            nxt
);

    logic             take;
    logic [REM_W-1:0] diff;

    assign take = cur.rem >= REM_W'(divisor);
    assign diff = take ? (cur.rem - REM_W'(divisor)) : cur.rem;

    // Remainder stays below twice the divisor, so the shift cannot overflow.
    assign nxt.rem = {diff[REM_W-2:0], 1'b0};
    assign nxt.q   = {cur.q[Q_W-2:0], take};

endmodule

`default_nettype wire

/* design/sgvs_place.sv */
// Round a scaled offset to Q16.8, add it to the position and saturate.
`default_nettype none

module sgvs_place
    import sgvs_pkg::*;
(
    input  wire logic signed [POS_W-1:0]  pos,
    input  wire logic signed [PROD_W-1:0] prod,
    output logic             [POS_W-1:0]  coord
);

    logic [PROD_W:0]   biased;
    logic [26:0]       off;
    logic [POS_W+3:0]  sum;
    logic              fits;

    assign biased = {prod[PROD_W-1], prod} + ROUND_BIAS;
    // Arithmetic shift right by 22: floor of the biased product.
    assign off    = biased[PROD_W:22];
    assign sum    = {{4{pos[POS_W-1]}}, pos} + {off[26], off};
    assign fits   = (sum[POS_W+3:POS_W-1] == 5'b00000) || (sum[POS_W+3:POS_W-1] == 5'b11111);
    assign coord  = fits ? sum[POS_W-1:0] : (sum[POS_W+3] ? POS_MIN : POS_MAX);

endmodule

`default_nettype wire

/* design/star_glyph_vertex_shader.sv */
// Top level of the star glyph vertex shader: table, multiply, place and colour pipeline.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tdata (fields), s_tuser = cmd, s_tlast = last_vertex
//  m_       out  m_tvalid / m_tready    m_tdata (vertex, colour), m_tuser = visible, m_tlast
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while s_tready is high; a generate item's result passes
// through the two multiplier stages, the eight-step colour divider and the output register.
// Write items update the table at their transfer and give no result.
// Reset clears all valid flags and loads the configuration defaults; the table is
// not cleared.
// Each stage advances when the one after it is empty or moving, so bubbles close
// up and input keeps flowing while a result waits on m_tready, as long as a stage is empty.
`default_nettype none

module star_glyph_vertex_shader
    import sgvs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // vert_index[9:0], base_x[25:10], base_y[41:26], base_z[57:42], pos_x[81:58],
    // pos_y[105:82], pos_z[129:106], radius[145:130], err_value[161:146],
    // aniso_value[177:162], zero pad[183:178]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // cmd[0]
    input  wire logic [0:0]            s_tuser,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // out_x[23:0], out_y[47:24], out_z[71:48], red[79:72], green[87:80], blue[95:88]
    output logic      [M_DATA_W-1:0]   m_tdata,
    // visible[0]
    output logic      [0:0]            m_tuser,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // ---------------------------------------------------------------- fields
    logic [IDX_W-1:0]          in_idx;
    logic [ENTRY_W-1:0]        in_base;
    logic signed [POS_W-1:0]   in_pos_x;
    logic signed [POS_W-1:0]   in_pos_y;
    logic signed [POS_W-1:0]   in_pos_z;
    logic [RAD_W-1:0]          in_radius;
    logic signed [ERR_W-1:0]   in_err;
    logic [ANISO_W-1:0]        in_aniso;

    assign in_idx    = s_tdata[9:0];
    assign in_base   = s_tdata[57:10];
    assign in_pos_x  = s_tdata[81:58];
    assign in_pos_y  = s_tdata[105:82];
    assign in_pos_z  = s_tdata[129:106];
    assign in_radius = s_tdata[145:130];
    assign in_err    = s_tdata[161:146];
    assign in_aniso  = s_tdata[177:162];

    // --------------------------------------------------------- configuration
    logic [SCALE_W-1:0] scale_reg,        scale_next;
    logic [THR_W-1:0]   err_thresh_reg,   err_thresh_next;
    logic [ANISO_W-1:0] aniso_thresh_reg, aniso_thresh_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        scale_next        = scale_reg;
        err_thresh_next   = err_thresh_reg;
        aniso_thresh_next = aniso_thresh_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALE:        scale_next        = cfg_data;
                CFG_ERR_THRESH:   err_thresh_next   = cfg_data[THR_W-1:0];
                CFG_ANISO_THRESH: aniso_thresh_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg        <= SCALE_RST;
            err_thresh_reg   <= ERR_THRESH_RST;
            aniso_thresh_reg <= ANISO_RST;
        end else begin
            scale_reg        <= scale_next;
            err_thresh_reg   <= err_thresh_next;
            aniso_thresh_reg <= aniso_thresh_next;
        end
    end

    // ------------------------------------------------------------ handshakes
    logic                 st1_vld_reg, st1_vld_next;
    logic                 st2_vld_reg, st2_vld_next;
    logic [DIV_STEPS-1:0] dv_vld_reg,  dv_vld_next;
    logic                 m_vld_reg,   m_vld_next;

    logic                 out_rdy;
    logic [DIV_STEPS-1:0] rdy_dv;
    logic                 rdy_st2;
    logic                 rdy_st1;
    logic                 s_xfer;

    always_comb begin
        out_rdy = !m_vld_reg || m_tready;
        rdy_dv[DIV_STEPS-1] = !dv_vld_reg[DIV_STEPS-1] || out_rdy;
        for (int j = DIV_STEPS - 2; j >= 0; j--) begin
            rdy_dv[j] = !dv_vld_reg[j] || rdy_dv[j+1];
        end
        rdy_st2 = !st2_vld_reg || rdy_dv[0];
        rdy_st1 = !st1_vld_reg || rdy_st2;
    end

    assign s_tready = rdy_st1;
    assign s_xfer   = s_tvalid && s_tready;

    // ----------------------------------------------------------------- table
    // A read and the write of an earlier item never meet on one edge: the write
    // lands at its own transfer, so a generate in the next cycle sees new data.
    logic [31:0]         idx_wide;
    logic [ADDR_W-1:0]   tab_addr;
    logic                in_range;
    logic                tab_we;
    logic [ENTRY_W-1:0]  tab_rdata;

    assign idx_wide = 32'(in_idx);
    assign tab_addr = idx_wide[ADDR_W-1:0];
    assign in_range = idx_wide < 32'(TABLE_DEPTH);
    assign tab_we   = s_xfer && (s_tuser[0] == CMD_WRITE) && in_range;

    sgvs_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (ADDR_W)
    ) u_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_addr),
        .wdata (in_base),
        .re    (rdy_st1),
        .raddr (tab_addr),
        .rdata (tab_rdata)
    );

    // --------------------------------------------- stage 1: gain, error mag
    st1_t               st1_reg, st1_next;
    logic [THR_W-1:0]   thr_eff;
    logic [ERR_W:0]     err_ext;
    logic [ERR_W:0]     err_abs;

    always_comb begin
        thr_eff  = (err_thresh_reg == '0) ? THR_W'(1) : err_thresh_reg;
        err_ext  = {in_err[ERR_W-1], in_err};
        err_abs  = in_err[ERR_W-1] ? ((ERR_W+1)'(0) - err_ext) : err_ext;

        st1_next          = st1_reg;
        st1_vld_next      = st1_vld_reg;
        if (rdy_st1) begin
            st1_vld_next      = s_xfer && (s_tuser[0] == CMD_GEN);
            st1_next.in_range = in_range;
            st1_next.vis      = in_aniso > aniso_thresh_reg;
            st1_next.err_pos  = !in_err[ERR_W-1] && (in_err != '0);
            st1_next.last     = s_tlast;
            st1_next.pos_x    = in_pos_x;
            st1_next.pos_y    = in_pos_y;
            st1_next.pos_z    = in_pos_z;
            st1_next.gain     = GAIN_W'(scale_reg) * GAIN_W'(in_radius);
            st1_next.mag      = (err_abs > (ERR_W+1)'(thr_eff)) ? thr_eff : err_abs[THR_W-1:0];
            st1_next.thr      = thr_eff;
        end
    end

    // ---------------------------------- stage 2: products, divider numerator
    st2_t                     st2_reg, st2_next;
    logic signed [BASE_W-1:0] bx, by, bz;
    logic signed [PROD_W:0]   px, py, pz;
    logic signed [GAIN_W:0]   gain_s;

    always_comb begin
        // Indexes past the table use a zero base vertex.
        bx     = st1_reg.in_range ? $signed(tab_rdata[15:0])  : '0;
        by     = st1_reg.in_range ? $signed(tab_rdata[31:16]) : '0;
        bz     = st1_reg.in_range ? $signed(tab_rdata[47:32]) : '0;
        gain_s = $signed({1'b0, st1_reg.gain});
        px     = gain_s * bx;
        py     = gain_s * by;
        pz     = gain_s * bz;

        st2_next     = st2_reg;
        st2_vld_next = st2_vld_reg;
        if (rdy_st2) begin
            st2_vld_next     = st1_vld_reg;
            st2_next.vis     = st1_reg.vis;
            st2_next.err_pos = st1_reg.err_pos;
            st2_next.last    = st1_reg.last;
            st2_next.pos_x   = st1_reg.pos_x;
            st2_next.pos_y   = st1_reg.pos_y;
            st2_next.pos_z   = st1_reg.pos_z;
            st2_next.prod_x  = PROD_W'(px);
            st2_next.prod_y  = PROD_W'(py);
            st2_next.prod_z  = PROD_W'(pz);
            // ceil(255 * mag / thr) is floor((255 * mag + thr - 1) / thr).
            st2_next.num     = REM_W'({st1_reg.mag, 8'b0}) - REM_W'(st1_reg.mag)
                             + REM_W'(st1_reg.thr) - REM_W'(1);
            st2_next.thr     = st1_reg.thr;
        end
    end

    // ---------------------------------- divider stages, placement in the first
    dv_t              dv_reg  [DIV_STEPS];
    dv_t              dv_next [DIV_STEPS];
    div_state_t       step_in  [DIV_STEPS];
    div_state_t       step_out [DIV_STEPS];
    logic [DIV_W-1:0] step_div [DIV_STEPS];
    logic [POS_W-1:0] place_x, place_y, place_z;

    sgvs_place u_place_x (.pos(st2_reg.pos_x), .prod(st2_reg.prod_x), .coord(place_x));
    sgvs_place u_place_y (.pos(st2_reg.pos_y), .prod(st2_reg.prod_y), .coord(place_y));
    sgvs_place u_place_z (.pos(st2_reg.pos_z), .prod(st2_reg.prod_z), .coord(place_z));

    always_comb begin
        step_in[0]  = '{rem: st2_reg.num, q: '0};
        step_div[0] = {st2_reg.thr, 7'b0};
        for (int j = 1; j < DIV_STEPS; j++) begin
            step_in[j]  = dv_reg[j-1].ds;
            step_div[j] = dv_reg[j-1].div;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        sgvs_div_step u_step (
            .cur     (step_in[g]),
            .divisor (step_div[g]),
            .nxt     (step_out[g])
        );
    end

    always_comb begin
        dv_vld_next = dv_vld_reg;
        for (int j = 0; j < DIV_STEPS; j++) begin
            dv_next[j] = dv_reg[j];
        end
        if (rdy_dv[0]) begin
            dv_vld_next[0]     = st2_vld_reg;
            dv_next[0].vis     = st2_reg.vis;
            dv_next[0].err_pos = st2_reg.err_pos;
            dv_next[0].last    = st2_reg.last;
            dv_next[0].x       = place_x;
            dv_next[0].y       = place_y;
            dv_next[0].z       = place_z;
            dv_next[0].div     = step_div[0];
            dv_next[0].ds      = step_out[0];
        end
        for (int j = 1; j < DIV_STEPS; j++) begin
            if (rdy_dv[j]) begin
                dv_vld_next[j] = dv_vld_reg[j-1];
                dv_next[j]     = dv_reg[j-1];
                dv_next[j].ds  = step_out[j];
            end
        end
    end

    // ---------------------------------------------------- output register
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;
    logic                m_last_reg, m_last_next;
    logic [CH_W-1:0]     dim;
    dv_t                 tail;

    always_comb begin
        tail        = dv_reg[DIV_STEPS-1];
        dim         = ~tail.ds.q;        // 255 - q
        m_vld_next  = m_vld_reg;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        m_last_next = m_last_reg;
        if (out_rdy) begin
            m_vld_next  = dv_vld_reg[DIV_STEPS-1];
            m_user_next = tail.vis;
            m_last_next = tail.last;
            if (!tail.vis) begin
                // Culled point: zero vertex and colour.
                m_data_next = '0;
            end else if (tail.err_pos) begin
                m_data_next = {dim, CH_FULL, dim, tail.z, tail.y, tail.x};
            end else begin
                m_data_next = {CH_FULL, dim, CH_FULL, tail.z, tail.y, tail.x};
            end
        end
    end

    assign m_tvalid   = m_vld_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

    // ------------------------------------------------------------ registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            dv_vld_reg  <= '0;
            m_vld_reg   <= 1'b0;
        end else begin
            st1_vld_reg <= st1_vld_next;
            st2_vld_reg <= st2_vld_next;
            dv_vld_reg  <= dv_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        st1_reg    <= st1_next;
        st2_reg    <= st2_next;
        for (int j = 0; j < DIV_STEPS; j++) begin
            dv_reg[j] <= dv_next[j];
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    // ----------------------------------------------------------- assertions
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[DIV_STEPS-1] |->
            (dv_reg[DIV_STEPS-1].ds.rem < {dv_reg[DIV_STEPS-1].div, 1'b0}))
        else $error("divider remainder out of range");

    a_culled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("culled result carries non-zero payload");

    a_colour_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            ((m_tdata[79:72] == m_tdata[95:88]) &&
             ((m_tdata[79:72] == CH_FULL) || (m_tdata[87:80] == CH_FULL))))
        else $error("visible colour not a white-to-green or white-to-magenta blend");

    a_tail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_vld_reg[DIV_STEPS-1] && !out_rdy) |=>
            (dv_vld_reg[DIV_STEPS-1] && $stable(dv_reg[DIV_STEPS-1].ds)))
        else $error("last divider stage lost its item under stall");

endmodule

`default_nettype wire
